// ===== rtl/plate_key_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// plate key table assertion macros
// shared concurrent assertion forms for the plate key table modules
// ----------------------------------------------------------------------------
`ifndef PLATE_KEY_TABLE_UNIT_MACROS_SVH
`define PLATE_KEY_TABLE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define PKT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define PKT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pkt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate key table package
// field widths, codes, controller/datapath structs and key format helpers
// ----------------------------------------------------------------------------
package pkt_pkg;

   localparam int KIND_W   = 2;
   localparam int CHARS_W  = 64;
   localparam int LEN_W    = 4;
   localparam int IDX_W    = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
   localparam logic [LEN_W-1:0] LEN_SHORT = 4'd7;
   localparam logic [LEN_W-1:0] LEN_LONG  = 4'd8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_FIND   = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUP       = 3'd2,
      ST_INVALID   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_RANGE     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SLOT_NONE  = 2'd0,
      SLOT_HIT   = 2'd1,
      SLOT_COUNT = 2'd2
   } slot_src_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_DECIDE = 3'd1,
      S_SCAN   = 3'd2,
      S_READ   = 3'd3,
      S_OUT    = 3'd4
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHARS_W-1:0] key_chars;
      logic [LEN_W-1:0]   key_length;
      logic [IDX_W-1:0]   slot_index;
   } pkt_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    found_slot;
      logic [CHARS_W-1:0]  read_chars;
      logic [LEN_W-1:0]    read_length;
      logic [COUNT_W-1:0]  entry_count;
   } pkt_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      logic         scan_en;
      logic         read_slot;
      logic         set_result;
      status_type   res_status;
      slot_src_type res_src;
      logic         res_read;
      logic         append;
      logic         load_out;
   } pkt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              len_ok;
      logic              fmt_ok;
      logic              idx_out;
      logic              hit;
      logic              scan_done;
   } pkt_stat_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   // clear every byte at or past the key length
   function automatic logic [CHARS_W-1:0] mask_chars(input logic [CHARS_W-1:0] chars,
                                                     input logic [LEN_W-1:0]   len);
      logic [CHARS_W-1:0] m;
      m = chars;
      for (int i = 0; i < 8; i++) begin
         if (LEN_W'(i) >= len) begin
            m[8*i +: 8] = 8'h00;
         end
      end
      return m;
   endfunction

   // one or two letters, four digits, two letters
   function automatic logic format_ok(input logic [CHARS_W-1:0] w,
                                      input logic [LEN_W-1:0]   len);
      logic ok;
      ok = 1'b0;
      if (len == LEN_LONG) begin
         ok = is_letter(w[7:0]) && is_letter(w[15:8]) &&
              is_digit(w[23:16]) && is_digit(w[31:24]) &&
              is_digit(w[39:32]) && is_digit(w[47:40]) &&
              is_letter(w[55:48]) && is_letter(w[63:56]);
      end else if (len == LEN_SHORT) begin
         ok = is_letter(w[7:0]) &&
              is_digit(w[15:8]) && is_digit(w[23:16]) &&
              is_digit(w[31:24]) && is_digit(w[39:32]) &&
              is_letter(w[47:40]) && is_letter(w[55:48]);
      end
      return ok;
   endfunction

endpackage

// ===== rtl/pkt_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate key table channels
// valid/ready channel interfaces for request, response and csr write
// ----------------------------------------------------------------------------
interface pkt_req_if import pkt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [CHARS_W-1:0] key_chars;
   logic [LEN_W-1:0]   key_length;
   logic [IDX_W-1:0]   slot_index;

   modport source (output valid, kind, key_chars, key_length, slot_index, input ready);
   modport sink   (input valid, kind, key_chars, key_length, slot_index, output ready);
endinterface

interface pkt_rsp_if import pkt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    found_slot;
   logic [CHARS_W-1:0]  read_chars;
   logic [LEN_W-1:0]    read_length;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, found_slot, read_chars, read_length, entry_count,
                   input ready);
   modport sink   (input valid, status, found_slot, read_chars, read_length, entry_count,
                   output ready);
endinterface

interface pkt_csr_if import pkt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

// ===== rtl/pkt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate key table datapath
// key memory, fill count, scan pointer, comparator, result and output registers
// ----------------------------------------------------------------------------
`include "plate_key_table_unit_macros.svh"

module pkt_datapath import pkt_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  pkt_req_type      req_data,
   input  logic             csr_fire,
   input  logic [CAP_W-1:0] csr_capacity,
   input  pkt_cmd_type      cmd,
   output pkt_stat_type     stat,
   output pkt_rsp_type      rsp_data
);

   localparam int CW  = $clog2(MAX_SLOTS + 1);
   localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CMW = (CW > CAP_W) ? CW : CAP_W;
   localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [CW-1:0]      count_ff, count_in;
   pkt_req_type        req_ff, req_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_idx_ff, pend_idx_in;
   status_type         res_status_ff, res_status_in;
   logic [AW-1:0]      res_slot_ff, res_slot_in;
   logic [CHARS_W-1:0] res_chars_ff, res_chars_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;
   pkt_rsp_type        out_ff, out_in;

   logic [CHARS_W-1:0] key_mem [MAX_SLOTS];
   logic [LEN_W-1:0]   len_mem [MAX_SLOTS];
   logic [CHARS_W-1:0] rd_chars_ff;
   logic [LEN_W-1:0]   rd_len_ff;
   logic [AW-1:0]      rd_addr;

   logic [CHARS_W-1:0] masked;
   logic               issue;
   logic               match;

   assign masked  = mask_chars(req_ff.key_chars, req_ff.key_length);
   assign issue   = cmd.scan_en && (scan_idx_ff != count_ff);
   assign rd_addr = cmd.read_slot ? AW'(req_ff.slot_index) : scan_idx_ff[AW-1:0];
   assign match   = (rd_len_ff == req_ff.key_length) && (rd_chars_ff == masked);

   always_comb begin
      stat.kind      = req_ff.kind;
      stat.full      = (CMW'(count_ff) >= CMW'(capacity_ff)) ||
                       (count_ff >= CW'(MAX_SLOTS));
      stat.len_ok    = (req_ff.key_length == LEN_SHORT) || (req_ff.key_length == LEN_LONG);
      stat.fmt_ok    = format_ok(req_ff.key_chars, req_ff.key_length);
      stat.idx_out   = IXW'(req_ff.slot_index) >= IXW'(count_ff);
      stat.hit       = pend_ff && match;
      stat.scan_done = !pend_ff && (scan_idx_ff == count_ff);
   end

   always_comb begin
      capacity_in   = csr_fire ? csr_capacity : capacity_ff;
      req_in        = cmd.capture ? req_data : req_ff;
      count_in      = cmd.append ? count_ff + 1'b1 : count_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = issue;
      pend_idx_in   = issue ? scan_idx_ff[AW-1:0] : pend_idx_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_chars_in  = res_chars_ff;
      res_len_in    = res_len_ff;
      out_in        = out_ff;

      if (cmd.capture) begin
         scan_idx_in = '0;
      end else if (issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end

      if (cmd.set_result) begin
         res_status_in = cmd.res_status;
         unique case (cmd.res_src)
            SLOT_HIT:   res_slot_in = pend_idx_ff;
            SLOT_COUNT: res_slot_in = count_ff[AW-1:0];
            default:    res_slot_in = '0;
         endcase
         res_chars_in = cmd.res_read ? rd_chars_ff : '0;
         res_len_in   = cmd.res_read ? rd_len_ff : '0;
      end

      if (cmd.load_out) begin
         out_in.status      = res_status_ff;
         out_in.found_slot  = IDX_W'(res_slot_ff);
         out_in.read_chars  = res_chars_ff;
         out_in.read_length = res_len_ff;
         out_in.entry_count = COUNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         count_ff    <= '0;
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         count_ff    <= count_in;
         scan_idx_ff <= scan_idx_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      pend_idx_ff   <= pend_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_chars_ff  <= res_chars_in;
      res_len_ff    <= res_len_in;
      out_ff        <= out_in;
   end

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         key_mem[count_ff[AW-1:0]] <= masked;
         len_mem[count_ff[AW-1:0]] <= req_ff.key_length;
      end
      rd_chars_ff <= key_mem[rd_addr];
      rd_len_ff   <= len_mem[rd_addr];
   end

   assign rsp_data = out_ff;

   `PKT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_SLOTS), "fill count above table size")
   `PKT_ASSERT_NEXT(a_append_count, clock, reset, cmd.append, count_ff == $past(count_ff) + 1'b1, "append did not bump count")
   `PKT_ASSERT_IMPL(a_hit_stored, clock, reset, stat.hit, CW'(pend_idx_ff) < count_ff, "hit on an unwritten slot")

endmodule

// ===== rtl/pkt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate key table controller
// sequences capture, decision, memory scan or read, and result hand-off
// ----------------------------------------------------------------------------
`include "plate_key_table_unit_macros.svh"

module pkt_ctrl import pkt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_ready,
   input  pkt_stat_type stat,
   output pkt_cmd_type  cmd,
   output logic         req_ready,
   output logic         rsp_valid
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (stat.kind)
               KIND_INSERT: state_in = (stat.full || !stat.len_ok) ? S_OUT : S_SCAN;
               KIND_FIND:   state_in = stat.len_ok ? S_SCAN : S_OUT;
               KIND_READ:   state_in = stat.idx_out ? S_OUT : S_READ;
               default:     state_in = S_OUT;
            endcase
         end
         S_SCAN: begin
            if (stat.hit || stat.scan_done) begin
               state_in = S_OUT;
            end
         end
         S_READ: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECIDE: begin
            unique case (stat.kind)
               KIND_INSERT: begin
                  if (stat.full) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = ST_FULL;
                  end else if (!stat.len_ok) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = ST_INVALID;
                  end
               end
               KIND_FIND: begin
                  if (!stat.len_ok) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = ST_NOT_FOUND;
                  end
               end
               KIND_READ: begin
                  if (stat.idx_out) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = ST_RANGE;
                  end else begin
                     cmd.read_slot = 1'b1;
                  end
               end
               default: begin
                  cmd.set_result = 1'b1;
                  cmd.res_status = ST_INVALID;
               end
            endcase
         end
         S_SCAN: begin
            if (stat.hit) begin
               cmd.set_result = 1'b1;
               cmd.res_src    = SLOT_HIT;
               cmd.res_status = (stat.kind == KIND_INSERT) ? ST_DUP : ST_OK;
            end else if (stat.scan_done) begin
               cmd.set_result = 1'b1;
               if (stat.kind == KIND_INSERT) begin
                  if (stat.fmt_ok) begin
                     cmd.append     = 1'b1;
                     cmd.res_status = ST_OK;
                     cmd.res_src    = SLOT_COUNT;
                  end else begin
                     cmd.res_status = ST_INVALID;
                  end
               end else begin
                  cmd.res_status = ST_NOT_FOUND;
               end
            end else begin
               cmd.scan_en = 1'b1;
            end
         end
         S_READ: begin
            cmd.set_result = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_read   = 1'b1;
         end
         S_OUT: cmd.load_out = out_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   `PKT_ASSERT_IMPL(a_no_overwrite, clock, reset, cmd.load_out, !out_valid_ff || rsp_ready, "result overwritten before taken")
   `PKT_ASSERT_NEXT(a_capture_decide, clock, reset, state_ff == S_IDLE && req_valid, state_ff == S_DECIDE, "accepted item not decided")
   `PKT_ASSERT_IMPL(a_append_legal, clock, reset, cmd.append, stat.fmt_ok && !stat.full && stat.kind == KIND_INSERT, "append of a rejected key")

endmodule

// ===== rtl/plate_key_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate key table unit
// result path: rejects go from capture through decide and the result register to the
//   output register; read adds a key memory read; insert and find scan the stored keys
//   one per cycle through the single read port of the key memory
// throughput: one item at a time; the next item is taken the cycle after its
//   result enters the output register. reset empties the table, capacity 16
// ----------------------------------------------------------------------------
module plate_key_table_unit import pkt_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input logic      clock,
   input logic      reset,
   pkt_req_if.sink  req_chan,
   pkt_rsp_if.source rsp_chan,
   pkt_csr_if.sink  csr_chan
);

   pkt_req_type  req_data;
   pkt_rsp_type  rsp_data;
   pkt_cmd_type  cmd;
   pkt_stat_type stat;
   logic         ctrl_req_ready;
   logic         ctrl_rsp_valid;

   // request item flattened into one struct for the datapath capture register
   assign req_data.kind       = req_chan.kind;
   assign req_data.key_chars  = req_chan.key_chars;
   assign req_data.key_length = req_chan.key_length;
   assign req_data.slot_index = req_chan.slot_index;

   // only the idle state takes an item; the output register stays independent
   assign req_chan.ready = ctrl_req_ready;

   // capacity register takes a write on any cycle
   assign csr_chan.ready = 1'b1;

   // result item straight from the output register
   assign rsp_chan.valid       = ctrl_rsp_valid;
   assign rsp_chan.status      = rsp_data.status;
   assign rsp_chan.found_slot  = rsp_data.found_slot;
   assign rsp_chan.read_chars  = rsp_data.read_chars;
   assign rsp_chan.read_length = rsp_data.read_length;
   assign rsp_chan.entry_count = rsp_data.entry_count;

   // sequencer: capture, decide, scan or read, hand off
   pkt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid)
   );

   // key memory, fill count, comparator and result registers
   pkt_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_fire     (csr_chan.valid),
      .csr_capacity (csr_chan.capacity),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plate key table unit testbench
// a short directed table and then phases of random insert, find and read
// traffic at several capacities; every result is checked against an
// in-bench model of the key table, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_top;
   import pkt_pkg::*;

   localparam int SLOTS     = 16;
   localparam int HALF_NS   = 6;
   localparam int LIMIT_NS  = 7_200_000;   // watchdog limit, in ns
   localparam int HOLD_LEN  = 400;         // long receiver hold-off, in cycles
   localparam int N_PHASES  = 8;
   localparam int SHOW_MAX  = 10;

   // the one kind code with no operation behind it
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   // capacity, idling and size of each random phase; the last runs flat out
   localparam int PHASE_CAP   [N_PHASES] = '{0, 5, 8, 11, 14, 31, 3, 16};
   localparam int PHASE_IDLE  [N_PHASES] = '{1, 1, 0, 1, 1, 1, 1, 0};
   localparam int PHASE_ITEMS [N_PHASES] = '{150, 200, 200, 200, 200, 250, 200, 225};
   localparam int HOLD_PHASE  = 3;

   typedef struct {
      logic             cap_wr;    // write capacity before this item
      logic [CAP_W-1:0] cap_val;
      pkt_req_type      item;
      logic             given;     // expectation typed into the table
      pkt_rsp_type      want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   pkt_req_if req_chan ();
   pkt_rsp_if rsp_chan ();
   pkt_csr_if csr_chan ();

   plate_key_table_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #(HALF_NS) clock = 1'b1;
      #(HALF_NS) clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // key table model: contents, fill level and capacity as the block sees them
   // ---------------------------------------------------------------------------
   logic [CHARS_W-1:0] key_tab [SLOTS] = '{default: '0};
   logic [LEN_W-1:0]   len_tab [SLOTS] = '{default: '0};
   int                 n_keys  = 0;
   int                 cap_reg = int'(CAP_RESET);

   pkt_rsp_type answers_due [$];   // results still owed by the block, oldest first
   int          mismatches  = 0;
   logic        idle_on     = 1'b1;
   logic        hold_req    = 1'b0;
   dir_row_type dir_tab [$];

   // letters fold to lower case by setting bit 5
   function automatic bit is_alpha(input logic [7:0] c);
      logic [7:0] f;
      f = c | 8'h20;
      return (f >= 8'h61) && (f <= 8'h7a);
   endfunction

   function automatic bit is_num(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // only the first len characters carry meaning
   function automatic logic [CHARS_W-1:0] keep_chars(input logic [CHARS_W-1:0] w,
                                                     input logic [LEN_W-1:0]   len);
      if (len >= 4'd8) return w;
      return w & ((64'd1 << (8 * len)) - 64'd1);
   endfunction

   // lead letters (one or two), four digits, two letters
   function automatic bit plate_shape_ok(input logic [CHARS_W-1:0] w,
                                         input logic [LEN_W-1:0]   len);
      int lead;
      bit ok;
      if (len != LEN_SHORT && len != LEN_LONG) return 1'b0;
      lead = int'(len) - 6;
      ok   = 1'b1;
      for (int i = 0; i < int'(len); i++) begin
         if (i >= lead && i < lead + 4) ok &= is_num(w[8*i +: 8]);
         else ok &= is_alpha(w[8*i +: 8]);
      end
      return ok;
   endfunction

   // first stored slot holding exactly this key, or -1
   function automatic int match_slot(input logic [CHARS_W-1:0] w,
                                     input logic [LEN_W-1:0]   len);
      logic [CHARS_W-1:0] m;
      if (len > 4'd8) return -1;
      m = keep_chars(w, len);
      for (int i = 0; i < n_keys; i++) begin
         if (len_tab[i] == len && key_tab[i] == m) return i;
      end
      return -1;
   endfunction

   // answer to one accepted item; appends to the model table on a good insert
   function automatic pkt_rsp_type plate_table_answer(input pkt_req_type it);
      pkt_rsp_type r;
      int          room;
      int          hit;
      r        = '0;
      r.status = ST_INVALID;
      room     = (cap_reg < SLOTS) ? cap_reg : SLOTS;
      hit      = match_slot(it.key_chars, it.key_length);
      case (it.kind)
         KIND_INSERT: begin
            if (n_keys >= room) begin
               r.status = ST_FULL;
            end else if (hit >= 0) begin
               r.status     = ST_DUP;
               r.found_slot = IDX_W'(hit);
            end else if (!plate_shape_ok(it.key_chars, it.key_length)) begin
               r.status = ST_INVALID;
            end else begin
               key_tab[n_keys] = keep_chars(it.key_chars, it.key_length);
               len_tab[n_keys] = it.key_length;
               r.status        = ST_OK;
               r.found_slot    = IDX_W'(n_keys);
               n_keys++;
            end
         end
         KIND_FIND: begin
            if (hit >= 0) begin
               r.status     = ST_OK;
               r.found_slot = IDX_W'(hit);
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         KIND_READ: begin
            if (int'(it.slot_index) >= n_keys) begin
               r.status = ST_RANGE;
            end else begin
               r.status      = ST_OK;
               r.read_chars  = key_tab[it.slot_index];
               r.read_length = len_tab[it.slot_index];
            end
         end
         default: ;   // spare kind: invalid, nothing changes
      endcase
      r.entry_count = COUNT_W'(n_keys);
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic logic [CHARS_W-1:0] txt(input string s);
      logic [CHARS_W-1:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic logic [7:0] rand_letter();
      return 8'($urandom_range(0, 1) ? 65 : 97) + 8'($urandom_range(0, 25));
   endfunction

   // well-formed plate of length 7 or 8
   function automatic logic [CHARS_W-1:0] rand_plate(input int len);
      logic [CHARS_W-1:0] w;
      int                 lead;
      w    = '0;
      lead = len - 6;
      for (int i = 0; i < len; i++) begin
         if (i >= lead && i < lead + 4) w[8*i +: 8] = 8'(48 + $urandom_range(0, 9));
         else w[8*i +: 8] = rand_letter();
      end
      return w;
   endfunction

   // mostly plate-shaped keys, fresh or taken from the table, some spoilt
   function automatic pkt_req_type pick_item();
      pkt_req_type        it;
      logic [CHARS_W-1:0] base;
      int                 r, s, len, j, pos;
      it.kind       = KIND_INSERT;
      it.key_chars  = {$urandom, $urandom};
      it.key_length = LEN_W'($urandom);
      it.slot_index = IDX_W'($urandom);
      r   = $urandom_range(0, 99);
      len = $urandom_range(7, 8);
      j   = (n_keys > 0) ? $urandom_range(0, n_keys - 1) : -1;
      pos = $urandom_range(0, 7);
      if (r < 64) begin
         it.kind = (r < 32) ? KIND_INSERT : KIND_FIND;
         s = $urandom_range(0, 9);
         if (s <= 8) begin
            if (s >= 4 && j >= 0) begin
               base = key_tab[j];
               len  = int'(len_tab[j]);
            end else begin
               base = rand_plate(len);
            end
            // rubbish past the end of a short key
            if (len == 7 && $urandom_range(0, 1)) base[63:56] = 8'($urandom);
            if (s == 7) base[8*pos +: 8] = 8'($urandom);
            it.key_chars  = base;
            it.key_length = (s == 8) ? LEN_W'($urandom) : LEN_W'(len);
         end
      end else if (r < 90) begin
         it.kind = KIND_READ;
         if (j >= 0 && $urandom_range(0, 3) != 0) it.slot_index = IDX_W'(j);
      end else begin
         it.kind = KIND_W'($urandom);
      end
      return it;
   endfunction

   function automatic dir_row_type row(input logic [KIND_W-1:0] kind,
                                       input logic [CHARS_W-1:0] w, input int len,
                                       input int idx);
      dir_row_type d;
      d.cap_wr          = 1'b0;
      d.cap_val         = '0;
      d.item.kind       = kind;
      d.item.key_chars  = w;
      d.item.key_length = LEN_W'(len);
      d.item.slot_index = IDX_W'(idx);
      d.given           = 1'b0;
      d.want            = '0;
      return d;
   endfunction

   function automatic dir_row_type row_k(input logic [KIND_W-1:0] kind,
                                         input logic [CHARS_W-1:0] w, input int len,
                                         input int idx,
                                         input status_type st, input int slot,
                                         input logic [CHARS_W-1:0] rch, input int rlen,
                                         input int cnt);
      dir_row_type d;
      d                  = row(kind, w, len, idx);
      d.given            = 1'b1;
      d.want.status      = st;
      d.want.found_slot  = IDX_W'(slot);
      d.want.read_chars  = rch;
      d.want.read_length = LEN_W'(rlen);
      d.want.entry_count = COUNT_W'(cnt);
      return d;
   endfunction

   function automatic dir_row_type with_cap(input dir_row_type d, input int v);
      d.cap_wr  = 1'b1;
      d.cap_val = CAP_W'(v);
      return d;
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------
   task automatic offer(input pkt_req_type it, input logic given, input pkt_rsp_type want);
      pkt_rsp_type model;
      // occasional burst of idle cycles before the item
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.kind       <= it.kind;
      req_chan.key_chars  <= it.key_chars;
      req_chan.key_length <= it.key_length;
      req_chan.slot_index <= it.slot_index;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // accepted at this edge: the model moves on now
      model = plate_table_answer(it);
      answers_due.push_back(given ? want : model);
   endtask

   // capacity only changes with the block drained
   task automatic set_capacity(input int v);
      req_chan.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      csr_chan.valid    <= 1'b1;
      csr_chan.capacity <= CAP_W'(v);
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      cap_reg = v;
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------
   function automatic void flag_fail(input string msg);
      mismatches++;
      if (mismatches <= SHOW_MAX) $display("%0t ns: %s", $time, msg);
   endfunction

   task automatic check_answer();
      pkt_rsp_type want;
      if (answers_due.size() == 0) begin
         flag_fail($sformatf("result with nothing outstanding, status %0d",
                             rsp_chan.status));
      end else begin
         want = answers_due.pop_front();
         if (rsp_chan.status !== want.status || rsp_chan.found_slot !== want.found_slot ||
             rsp_chan.read_chars !== want.read_chars ||
             rsp_chan.read_length !== want.read_length ||
             rsp_chan.entry_count !== want.entry_count) begin
            flag_fail($sformatf({"result mismatch: exp st %0d slot %0d chars %h len %0d cnt %0d,",
                                 " got st %0d slot %0d chars %h len %0d cnt %0d"},
                                want.status, want.found_slot, want.read_chars,
                                want.read_length, want.entry_count,
                                rsp_chan.status, rsp_chan.found_slot, rsp_chan.read_chars,
                                rsp_chan.read_length, rsp_chan.entry_count));
         end
      end
   endtask

   // receiver: random stall bursts, plus one long hold-off to back the block up
   initial begin
      int   stall;
      int   hold_left;
      logic held;
      stall          = 0;
      hold_left      = 0;
      held           = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) check_answer();
         if (hold_req && !held) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(0, 4);   // ready drops now and stays low while the stall count runs down
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      dir_row_type d;
      // known values on every input from the start
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_INSERT;
      req_chan.key_chars  = '0;
      req_chan.key_length = '0;
      req_chan.slot_index = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.capacity   = CAP_RESET;

      // directed part, starting from an empty table at the reset capacity
      // read and find on an empty table
      dir_tab.push_back(row_k(KIND_READ, '0, 0, 0, ST_RANGE, 0, '0, 0, 0));
      dir_tab.push_back(row_k(KIND_FIND, txt("AB1234CD"), 8, 0, ST_NOT_FOUND, 0, '0, 0, 0));
      // two-letter plate, then the same again
      dir_tab.push_back(row_k(KIND_INSERT, txt("AB1234CD"), 8, 0, ST_OK, 0, '0, 0, 1));
      dir_tab.push_back(row_k(KIND_INSERT, txt("AB1234CD"), 8, 0, ST_DUP, 0, '0, 0, 1));
      // one-letter plate with rubbish past its end
      dir_tab.push_back(row_k(KIND_INSERT, txt("A1234BC") | {8'hff, 56'h0}, 7, 0,
                              ST_OK, 1, '0, 0, 2));
      dir_tab.push_back(row(KIND_FIND, txt("A1234BC") | {8'h5a, 56'h0}, 7, 0));
      dir_tab.push_back(row(KIND_READ, '0, 0, 1));
      // same characters, different length
      dir_tab.push_back(row(KIND_FIND, txt("AB1234C"), 7, 0));
      // letter and digit range ends
      dir_tab.push_back(row_k(KIND_INSERT, txt("Za9999zA"), 8, 0, ST_OK, 2, '0, 0, 3));
      dir_tab.push_back(row(KIND_INSERT, txt("@a0000zz"), 8, 0));
      dir_tab.push_back(row(KIND_INSERT, txt("Ab:000AB"), 8, 0));
      dir_tab.push_back(row(KIND_INSERT, txt("Ab0000Z["), 8, 0));
      // all-ones and all-zero keys
      dir_tab.push_back(row_k(KIND_INSERT, '1, 8, 0, ST_INVALID, 0, '0, 0, 3));
      dir_tab.push_back(row_k(KIND_INSERT, '0, 0, 0, ST_INVALID, 0, '0, 0, 3));
      // long keys never match and never go in
      dir_tab.push_back(row_k(KIND_INSERT, txt("AB1234CD"), 9, 0, ST_INVALID, 0, '0, 0, 3));
      dir_tab.push_back(row_k(KIND_FIND, txt("AB1234CD"), 9, 0, ST_NOT_FOUND, 0, '0, 0, 3));
      dir_tab.push_back(row_k(KIND_INSERT, '1, 15, 15, ST_INVALID, 0, '0, 0, 3));
      // spare kind code
      dir_tab.push_back(row_k(KIND_SPARE, '1, 15, 15, ST_INVALID, 0, '0, 0, 3));
      // reads past the fill level
      dir_tab.push_back(row_k(KIND_READ, '0, 0, 15, ST_RANGE, 0, '0, 0, 3));
      dir_tab.push_back(row_k(KIND_READ, '0, 0, 3, ST_RANGE, 0, '0, 0, 3));
      // capacity dropped below the fill level: full wins over duplicate and format
      dir_tab.push_back(with_cap(row_k(KIND_INSERT, txt("AB1234CD"), 8, 0,
                                       ST_FULL, 0, '0, 0, 3), 2));
      dir_tab.push_back(row_k(KIND_INSERT, txt("QQ5555RR"), 8, 0, ST_FULL, 0, '0, 0, 3));
      dir_tab.push_back(row(KIND_FIND, txt("Za9999zA"), 8, 0));
      // zero capacity
      dir_tab.push_back(with_cap(row_k(KIND_INSERT, txt("B7777XY"), 7, 0,
                                       ST_FULL, 0, '0, 0, 3), 0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         d = dir_tab[i];
         if (d.cap_wr) set_capacity(int'(d.cap_val));
         offer(d.item, d.given, d.want);
      end

      // random phases; some capacities fall below the fill level reached so far
      for (int p = 0; p < N_PHASES; p++) begin
         set_capacity(PHASE_CAP[p]);
         idle_on = PHASE_IDLE[p][0];
         if (p == HOLD_PHASE) hold_req = 1'b1;
         for (int i = 0; i < PHASE_ITEMS[p]; i++) offer(pick_item(), 1'b0, '0);
      end

      // drain, then a short tail for anything stray
      req_chan.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
